// ===== rtl/amps_pkg.sv =====
package amps_pkg;

   // field widths
   localparam int TRACK_W  = 16;
   localparam int VOLUME_W = 6;
   localparam int REQ_VOL_W = 8;
   localparam int LEVEL_W  = 8;
   localparam int MS_W     = 32;

   // clamp limits for incoming requests
   localparam logic [TRACK_W-1:0]   MAX_TRACK  = 16'd255;
   localparam logic [REQ_VOL_W-1:0] MAX_VOLUME = 8'd30;

   typedef enum logic [1:0] {
      KIND_RUN     = 2'd0,
      KIND_REQUEST = 2'd1,
      KIND_EDGE    = 2'd2,
      KIND_NONE    = 2'd3
   } amps_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE        = 4'd0,
      ST_TURN_ON     = 4'd1,
      ST_WAIT_BOOT   = 4'd2,
      ST_SET_VOLUME  = 4'd3,
      ST_WAIT_GAP    = 4'd4,
      ST_PLAY        = 4'd5,
      ST_WAIT_START  = 4'd6,
      ST_RESTART     = 4'd7,
      ST_WAIT_END    = 4'd8,
      ST_CHECK_QUEUE = 4'd9,
      ST_TRACK_GAP   = 4'd10,
      ST_TURN_OFF    = 4'd11
   } amps_state_type;

   typedef enum logic [3:0] {
      ACT_NONE        = 4'd0,
      ACT_POWER_UP    = 4'd1,
      ACT_SET_VOLUME  = 4'd2,
      ACT_PLAY        = 4'd3,
      ACT_RESTART_OFF = 4'd4,
      ACT_FAILED      = 4'd5,
      ACT_STOP        = 4'd6,
      ACT_POWER_DOWN  = 4'd7,
      ACT_QUEUED      = 4'd8,
      ACT_DROPPED     = 4'd9
   } amps_action_type;

   typedef enum logic [7:0] {
      CSR_BOOT_WAIT     = 8'd0,
      CSR_COMMAND_GAP   = 8'd1,
      CSR_START_WAIT    = 8'd2,
      CSR_START_RETRY   = 8'd3,
      CSR_RESTART_LIMIT = 8'd4,
      CSR_RESTART_OFF   = 8'd5,
      CSR_PLAY_TIMEOUT  = 8'd6,
      CSR_TRACK_GAP     = 8'd7
   } amps_csr_type;

   // one queued play request, already clamped
   typedef struct packed {
      logic [LEVEL_W-1:0]  blue;
      logic [LEVEL_W-1:0]  green;
      logic [LEVEL_W-1:0]  red;
      logic [VOLUME_W-1:0] volume;
      logic [TRACK_W-1:0]  track;
   } amps_entry_type;

   // classified item handed from front to back
   typedef struct packed {
      amps_kind_type  kind;
      logic [MS_W-1:0] now_ms;
      logic           busy_low;
      amps_entry_type entry;
   } amps_item_type;

   typedef struct packed {
      logic [15:0] boot_wait_ms;
      logic [15:0] command_gap_ms;
      logic [15:0] start_wait_ms;
      logic [7:0]  start_retry_limit;
      logic [7:0]  restart_limit;
      logic [15:0] restart_off_ms;
      logic [31:0] play_timeout_ms;
      logic [15:0] track_gap_ms;
   } amps_cfg_type;

   typedef struct packed {
      amps_action_type     action;
      logic [TRACK_W-1:0]  track;
      logic [VOLUME_W-1:0] volume;
      logic                color_set;
      logic [LEVEL_W-1:0]  red;
      logic [LEVEL_W-1:0]  green;
      logic [LEVEL_W-1:0]  blue;
      logic                module_power;
      amps_state_type      state;
   } amps_result_type;

endpackage

// ===== rtl/amps_front.sv =====
module amps_front import amps_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_cmd,
   input  logic [87:0]   req_data,
   output logic          q_valid,
   output amps_item_type q_item,
   input  logic          q_pop
);

   amps_item_type item_c;
   amps_item_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    fill_ff, fill_in;
   logic          push;
   logic          pop;
   logic [TRACK_W-1:0]   trk;
   logic [REQ_VOL_W-1:0] vol;

   // classify and clamp
   always_comb begin
      trk = req_data[48:33];
      vol = req_data[56:49];
      case (amps_kind_type'(req_cmd))
         KIND_RUN:     item_c.kind = KIND_RUN;
         KIND_REQUEST: item_c.kind = KIND_REQUEST;
         KIND_EDGE:    item_c.kind = KIND_EDGE;
         default:      item_c.kind = KIND_NONE;
      endcase
      item_c.now_ms       = req_data[31:0];
      item_c.busy_low     = req_data[32];
      item_c.entry.track  = (trk > MAX_TRACK) ? MAX_TRACK : trk;
      item_c.entry.volume = (vol > MAX_VOLUME) ? MAX_VOLUME[VOLUME_W-1:0]
                                               : vol[VOLUME_W-1:0];
      item_c.entry.red    = req_data[64:57];
      item_c.entry.green  = req_data[72:65];
      item_c.entry.blue   = req_data[80:73];
   end

   // two-slot queue toward the back end
   assign req_ready = (fill_ff != 2'd2);
   assign q_valid   = (fill_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_c;
      end
   end

endmodule

// ===== rtl/amps_back.sv =====
module amps_back import amps_pkg::*; #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  amps_cfg_type    cfg,
   input  logic            q_valid,
   input  amps_item_type   q_item,
   output logic            q_pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output amps_result_type rsp_result
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = IDX_W + 1;

   amps_state_type  state_ff, state_in;
   logic [MS_W-1:0] start_ff, start_in;
   logic [7:0]      retry_ff, retry_in;
   logic [7:0]      restart_ff, restart_in;
   logic            done_ff, done_in;
   logic            armed_ff, armed_in;
   logic            power_ff, power_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] head_ff, head_in;
   amps_entry_type  cur_ff;
   amps_entry_type  mem [QUEUE_DEPTH];

   logic            rsp_valid_ff, rsp_valid_in;
   amps_result_type result_ff;
   amps_result_type result_c;

   logic            take;
   logic            run;
   logic            wr_en;
   logic            pop_en;
   logic            fifo_full;
   logic            fifo_empty;
   logic [SUM_W-1:0] wr_sum;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] head_next;
   logic [MS_W-1:0] period;
   logic            elapsed;

   assign take  = q_valid && (!rsp_valid_ff || rsp_ready);
   assign q_pop = take;
   assign run   = take && (q_item.kind == KIND_RUN);

   assign fifo_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign fifo_empty = (count_ff == '0);
   assign wr_sum     = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign wr_addr    = (wr_sum >= SUM_W'(QUEUE_DEPTH)) ?
                       IDX_W'(wr_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(wr_sum);
   assign head_next  = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // one timer compare, period picked by the waiting state
   always_comb begin
      case (state_ff)
         ST_WAIT_BOOT:  period = {16'd0, cfg.boot_wait_ms};
         ST_WAIT_GAP:   period = {16'd0, cfg.command_gap_ms};
         ST_WAIT_START: period = {16'd0, cfg.start_wait_ms};
         ST_RESTART:    period = {16'd0, cfg.restart_off_ms};
         ST_WAIT_END:   period = cfg.play_timeout_ms;
         ST_TRACK_GAP:  period = {16'd0, cfg.track_gap_ms};
         default:       period = '0;
      endcase
   end
   assign elapsed = ((q_item.now_ms - start_ff) >= period);

   // next state
   always_comb begin
      state_in = state_ff;
      if (run) begin
         case (state_ff)
            ST_IDLE:       if (!fifo_empty) state_in = ST_TURN_ON;
            ST_TURN_ON:    state_in = ST_WAIT_BOOT;
            ST_WAIT_BOOT:  if (elapsed) state_in = ST_SET_VOLUME;
            ST_SET_VOLUME: state_in = ST_WAIT_GAP;
            ST_WAIT_GAP:   if (elapsed) state_in = ST_PLAY;
            ST_PLAY:       state_in = ST_WAIT_START;
            ST_WAIT_START: begin
               if (done_ff) begin
                  state_in = ST_CHECK_QUEUE;
               end else if (q_item.busy_low) begin
                  state_in = ST_WAIT_END;
               end else if (!elapsed) begin
                  state_in = ST_WAIT_START;
               end else if (retry_ff < cfg.start_retry_limit) begin
                  state_in = ST_PLAY;
               end else if (restart_ff < cfg.restart_limit) begin
                  state_in = ST_RESTART;
               end else begin
                  state_in = ST_CHECK_QUEUE;
               end
            end
            ST_RESTART:    if (elapsed) state_in = ST_TURN_ON;
            ST_WAIT_END:   if (done_ff || elapsed) state_in = ST_CHECK_QUEUE;
            ST_CHECK_QUEUE: state_in = fifo_empty ? ST_TURN_OFF : ST_TRACK_GAP;
            ST_TRACK_GAP: begin
               if (elapsed) state_in = fifo_empty ? ST_TURN_OFF : ST_SET_VOLUME;
            end
            ST_TURN_OFF:   state_in = ST_IDLE;
            default:       state_in = ST_IDLE;
         endcase
      end
   end

   // datapath and result
   always_comb begin
      start_in   = start_ff;
      retry_in   = retry_ff;
      restart_in = restart_ff;
      done_in    = done_ff;
      armed_in   = armed_ff;
      power_in   = power_ff;
      wr_en      = 1'b0;
      pop_en     = 1'b0;
      result_c   = '0;
      result_c.action = ACT_NONE;
      if (take) begin
         case (q_item.kind)
            KIND_REQUEST: begin
               result_c.track  = q_item.entry.track;
               result_c.volume = q_item.entry.volume;
               result_c.red    = q_item.entry.red;
               result_c.green  = q_item.entry.green;
               result_c.blue   = q_item.entry.blue;
               if (!fifo_full) begin
                  wr_en           = 1'b1;
                  result_c.action = ACT_QUEUED;
               end else begin
                  result_c.action = ACT_DROPPED;
               end
            end
            KIND_EDGE: begin
               if (armed_ff) done_in = 1'b1;
            end
            KIND_RUN: begin
               case (state_ff)
                  ST_IDLE: begin
                     if (!fifo_empty) pop_en = 1'b1;
                  end
                  ST_TURN_ON: begin
                     power_in        = 1'b1;
                     start_in        = q_item.now_ms;
                     result_c.action = ACT_POWER_UP;
                  end
                  ST_SET_VOLUME: begin
                     result_c.action    = ACT_SET_VOLUME;
                     result_c.volume    = cur_ff.volume;
                     result_c.red       = cur_ff.red;
                     result_c.green     = cur_ff.green;
                     result_c.blue      = cur_ff.blue;
                     result_c.color_set = |{cur_ff.red, cur_ff.green, cur_ff.blue};
                     start_in           = q_item.now_ms;
                  end
                  ST_PLAY: begin
                     armed_in        = 1'b1;
                     done_in         = 1'b0;
                     result_c.action = ACT_PLAY;
                     result_c.track  = cur_ff.track;
                     start_in        = q_item.now_ms;
                  end
                  ST_WAIT_START: begin
                     if (done_ff) begin
                        done_in = 1'b0;
                     end else if (q_item.busy_low) begin
                        start_in = q_item.now_ms;
                     end else if (!elapsed) begin
                        start_in = start_ff;
                     end else if (retry_ff < cfg.start_retry_limit) begin
                        retry_in = retry_ff + 8'd1;
                     end else if (restart_ff < cfg.restart_limit) begin
                        restart_in      = restart_ff + 8'd1;
                        retry_in        = 8'd0;
                        power_in        = 1'b0;
                        armed_in        = 1'b0;
                        start_in        = q_item.now_ms;
                        result_c.action = ACT_RESTART_OFF;
                     end else begin
                        result_c.action = ACT_FAILED;
                        result_c.track  = cur_ff.track;
                     end
                  end
                  ST_WAIT_END: begin
                     if (done_ff) done_in = 1'b0;
                     if (elapsed) result_c.action = ACT_STOP;
                  end
                  ST_CHECK_QUEUE: begin
                     if (!fifo_empty) start_in = q_item.now_ms;
                  end
                  ST_TRACK_GAP: begin
                     if (elapsed) begin
                        done_in = 1'b0;
                        if (!fifo_empty) pop_en = 1'b1;
                     end
                  end
                  ST_TURN_OFF: begin
                     power_in        = 1'b0;
                     armed_in        = 1'b0;
                     done_in         = 1'b0;
                     result_c.action = ACT_POWER_DOWN;
                  end
                  default: begin
                     start_in = start_ff;
                  end
               endcase
               if (pop_en) begin
                  retry_in   = 8'd0;
                  restart_in = 8'd0;
               end
            end
            default: begin
               result_c.action = ACT_NONE;
            end
         endcase
      end
      result_c.module_power = power_in;
      result_c.state        = state_in;
   end

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      if (wr_en) count_in = count_ff + 1'b1;
      if (pop_en) begin
         count_in = count_ff - 1'b1;
         head_in  = head_next;
      end
   end

   always_comb begin
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= '0;
         retry_ff     <= '0;
         restart_ff   <= '0;
         done_ff      <= 1'b0;
         armed_ff     <= 1'b0;
         power_ff     <= 1'b0;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         retry_ff     <= retry_in;
         restart_ff   <= restart_in;
         done_ff      <= done_in;
         armed_ff     <= armed_in;
         power_ff     <= power_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request memory: one write port, registered read into the current entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= q_item.entry;
      end
      if (pop_en) begin
         cur_ff <= mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_c;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

endmodule

// ===== rtl/audio_module_play_sequencer.sv =====
// path: an accepted req transaction waits in a front-end slot, then in the result register
// throughput: one transaction per cycle while rsp_tready is high; each item is one back-end
//   state update, with at most one write or one registered read of the request memory
// reset: synchronous, active high; clears the sequencer, queues and counters and loads the
//   register defaults; the request memory is not cleared
module audio_module_play_sequencer import amps_pkg::*; #(
   parameter int QUEUE_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   // input transaction
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // now_ms, busy_low, req_track, req_volume,
                                    // req_red, req_green, req_blue, zero fill
   input  logic [1:0]  req_tuser,   // cmd
   // result transaction
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // track_out, volume_out, color_set, red_out,
                                    // green_out, blue_out, module_power, state_code, zero fill
   output logic [3:0]  rsp_tuser,   // action
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);

   amps_cfg_type    cfg_ff, cfg_in;
   logic            q_valid;
   amps_item_type   q_item;
   logic            q_pop;
   amps_result_type result;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (amps_csr_type'(csr_index))
            CSR_BOOT_WAIT:     cfg_in.boot_wait_ms      = csr_data[15:0];
            CSR_COMMAND_GAP:   cfg_in.command_gap_ms    = csr_data[15:0];
            CSR_START_WAIT:    cfg_in.start_wait_ms     = csr_data[15:0];
            CSR_START_RETRY:   cfg_in.start_retry_limit = csr_data[7:0];
            CSR_RESTART_LIMIT: cfg_in.restart_limit     = csr_data[7:0];
            CSR_RESTART_OFF:   cfg_in.restart_off_ms    = csr_data[15:0];
            CSR_PLAY_TIMEOUT:  cfg_in.play_timeout_ms   = csr_data;
            CSR_TRACK_GAP:     cfg_in.track_gap_ms      = csr_data[15:0];
            // writes past the register list are ignored
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.boot_wait_ms      <= 16'd1500;
         cfg_ff.command_gap_ms    <= 16'd100;
         cfg_ff.start_wait_ms     <= 16'd500;
         cfg_ff.start_retry_limit <= 8'd2;
         cfg_ff.restart_limit     <= 8'd1;
         cfg_ff.restart_off_ms    <= 16'd1000;
         cfg_ff.play_timeout_ms   <= 32'd60000;
         cfg_ff.track_gap_ms      <= 16'd200;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: decode cmd, clamp request fields, hold up to two items
   amps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (req_tuser),
      .req_data  (req_tdata),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   // back end: request queue, play sequencer and result register
   amps_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   // result packing, lowest field first
   assign rsp_tuser = result.action;
   assign rsp_tdata = {4'd0,
                       result.state,
                       result.module_power,
                       result.blue,
                       result.green,
                       result.red,
                       result.color_set,
                       result.volume,
                       result.track};

endmodule

// ===== tb/sv/tb_audio_module_play_sequencer.sv =====
`timescale 1ns / 1ps

module tb_audio_module_play_sequencer;
   import amps_pkg::*;

   localparam int DEPTH       = 8;
   localparam int CYCLE_LIMIT = 200000;

   // one input transaction before packing
   typedef struct packed {
      amps_kind_type kind;
      logic [31:0]   now_ms;
      logic          busy_low;
      logic [15:0]   track;
      logic [7:0]    volume;
      logic [7:0]    red;
      logic [7:0]    green;
      logic [7:0]    blue;
   } play_item_type;

   // directed table row; fixed marks a result typed in by hand
   typedef struct packed {
      play_item_type   item;
      logic            fixed;
      amps_result_type want;
   } step_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index  = '0;
   logic [31:0] csr_data   = '0;

   audio_module_play_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // sequencer shadow: registers, state machine and request queue
   // ---------------------------------------------------------------
   amps_cfg_type   cfg;
   amps_state_type seq;
   logic [31:0]    ev_start;
   logic [7:0]     retries;
   logic [7:0]     restarts;
   logic           done_flag;
   logic           armed;
   logic           power;
   amps_entry_type cur;
   amps_entry_type fifo [DEPTH];
   int unsigned    fifo_n;
   int unsigned    fifo_rd;

   // expected results in transaction order
   amps_result_type outcome_q[$];

   step_row_type rows[$];
   logic [31:0] ms_now;
   int unsigned sent_n    = 0;
   int unsigned checked_n = 0;
   int unsigned errors    = 0;
   int unsigned cycles    = 0;
   int unsigned seen [16];

   function automatic void clear_sequencer();
      cfg.boot_wait_ms      = 16'd1500;
      cfg.command_gap_ms    = 16'd100;
      cfg.start_wait_ms     = 16'd500;
      cfg.start_retry_limit = 8'd2;
      cfg.restart_limit     = 8'd1;
      cfg.restart_off_ms    = 16'd1000;
      cfg.play_timeout_ms   = 32'd60000;
      cfg.track_gap_ms      = 16'd200;
      seq       = ST_IDLE;
      ev_start  = '0;
      retries   = '0;
      restarts  = '0;
      done_flag = 1'b0;
      armed     = 1'b0;
      power     = 1'b0;
      cur       = '0;
      fifo_n    = 0;
      fifo_rd   = 0;
   endfunction

   function automatic void apply_reg(logic [7:0] idx, logic [31:0] val);
      case (idx)
         CSR_BOOT_WAIT:     cfg.boot_wait_ms      = val[15:0];
         CSR_COMMAND_GAP:   cfg.command_gap_ms    = val[15:0];
         CSR_START_WAIT:    cfg.start_wait_ms     = val[15:0];
         CSR_START_RETRY:   cfg.start_retry_limit = val[7:0];
         CSR_RESTART_LIMIT: cfg.restart_limit     = val[7:0];
         CSR_RESTART_OFF:   cfg.restart_off_ms    = val[15:0];
         CSR_PLAY_TIMEOUT:  cfg.play_timeout_ms   = val;
         CSR_TRACK_GAP:     cfg.track_gap_ms      = val[15:0];
         default: ;
      endcase
   endfunction

   // wrap-safe wait check against the last event time
   function automatic logic due(logic [31:0] now, logic [31:0] period);
      logic [31:0] diff;
      diff = now - ev_start;
      return diff >= period;
   endfunction

   function automatic void take_next();
      cur      = fifo[fifo_rd];
      fifo_rd  = (fifo_rd + 1) % DEPTH;
      fifo_n   = fifo_n - 1;
      retries  = '0;
      restarts = '0;
   endfunction

   // one transaction through the sequencer, returns the result it causes
   function automatic amps_result_type play_step(play_item_type it);
      amps_result_type r;
      amps_entry_type  e;
      r = '0;
      r.action = ACT_NONE;
      case (it.kind)
         KIND_REQUEST: begin
            e.track  = (it.track > MAX_TRACK) ? MAX_TRACK : it.track;
            e.volume = (it.volume > MAX_VOLUME) ? VOLUME_W'(MAX_VOLUME) : it.volume[5:0];
            e.red    = it.red;
            e.green  = it.green;
            e.blue   = it.blue;
            r.track  = e.track;
            r.volume = e.volume;
            r.red    = e.red;
            r.green  = e.green;
            r.blue   = e.blue;
            if (fifo_n < DEPTH) begin
               fifo[(fifo_rd + fifo_n) % DEPTH] = e;
               fifo_n   = fifo_n + 1;
               r.action = ACT_QUEUED;
            end else begin
               r.action = ACT_DROPPED;
            end
         end
         KIND_EDGE: begin
            if (armed) done_flag = 1'b1;
         end
         KIND_RUN: begin
            case (seq)
               ST_IDLE: begin
                  if (fifo_n > 0) begin
                     take_next();
                     seq = ST_TURN_ON;
                  end
               end
               ST_TURN_ON: begin
                  power    = 1'b1;
                  ev_start = it.now_ms;
                  r.action = ACT_POWER_UP;
                  seq      = ST_WAIT_BOOT;
               end
               ST_WAIT_BOOT: begin
                  if (due(it.now_ms, 32'(cfg.boot_wait_ms))) seq = ST_SET_VOLUME;
               end
               ST_SET_VOLUME: begin
                  r.action    = ACT_SET_VOLUME;
                  r.volume    = cur.volume;
                  r.red       = cur.red;
                  r.green     = cur.green;
                  r.blue      = cur.blue;
                  // all-zero colour leaves the leds alone
                  r.color_set = |{cur.red, cur.green, cur.blue};
                  ev_start    = it.now_ms;
                  seq         = ST_WAIT_GAP;
               end
               ST_WAIT_GAP: begin
                  if (due(it.now_ms, 32'(cfg.command_gap_ms))) seq = ST_PLAY;
               end
               ST_PLAY: begin
                  armed     = 1'b1;
                  done_flag = 1'b0;
                  r.action  = ACT_PLAY;
                  r.track   = cur.track;
                  ev_start  = it.now_ms;
                  seq       = ST_WAIT_START;
               end
               ST_WAIT_START: begin
                  if (done_flag) begin
                     done_flag = 1'b0;
                     seq       = ST_CHECK_QUEUE;
                  end else if (it.busy_low) begin
                     ev_start = it.now_ms;
                     seq      = ST_WAIT_END;
                  end else if (!due(it.now_ms, 32'(cfg.start_wait_ms))) begin
                     // still waiting for playback
                  end else if (retries < cfg.start_retry_limit) begin
                     retries = retries + 8'd1;
                     seq     = ST_PLAY;
                  end else if (restarts < cfg.restart_limit) begin
                     restarts = restarts + 8'd1;
                     retries  = '0;
                     power    = 1'b0;
                     armed    = 1'b0;
                     ev_start = it.now_ms;
                     r.action = ACT_RESTART_OFF;
                     seq      = ST_RESTART;
                  end else begin
                     r.action = ACT_FAILED;
                     r.track  = cur.track;
                     seq      = ST_CHECK_QUEUE;
                  end
               end
               ST_RESTART: begin
                  if (due(it.now_ms, 32'(cfg.restart_off_ms))) seq = ST_TURN_ON;
               end
               ST_WAIT_END: begin
                  if (done_flag) begin
                     done_flag = 1'b0;
                     seq       = ST_CHECK_QUEUE;
                  end
                  // timeout wins even when the end event came too
                  if (due(it.now_ms, cfg.play_timeout_ms)) begin
                     r.action = ACT_STOP;
                     seq      = ST_CHECK_QUEUE;
                  end
               end
               ST_CHECK_QUEUE: begin
                  if (fifo_n == 0) begin
                     seq = ST_TURN_OFF;
                  end else begin
                     ev_start = it.now_ms;
                     seq      = ST_TRACK_GAP;
                  end
               end
               ST_TRACK_GAP: begin
                  if (due(it.now_ms, 32'(cfg.track_gap_ms))) begin
                     done_flag = 1'b0;
                     if (fifo_n > 0) begin
                        take_next();
                        seq = ST_SET_VOLUME;
                     end else begin
                        seq = ST_TURN_OFF;
                     end
                  end
               end
               ST_TURN_OFF: begin
                  power     = 1'b0;
                  armed     = 1'b0;
                  done_flag = 1'b0;
                  r.action  = ACT_POWER_DOWN;
                  seq       = ST_IDLE;
               end
               default: seq = ST_IDLE;
            endcase
         end
         default: ;   // unused command
      endcase
      r.module_power = power;
      r.state        = seq;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // directed table
   // ---------------------------------------------------------------
   function automatic void add(amps_kind_type k, logic [31:0] now, logic busy,
                               logic [15:0] trk, logic [7:0] vol,
                               logic [7:0] r, logic [7:0] g, logic [7:0] b);
      step_row_type row;
      row = '0;
      row.item.kind     = k;
      row.item.now_ms   = now;
      row.item.busy_low = busy;
      row.item.track    = trk;
      row.item.volume   = vol;
      row.item.red      = r;
      row.item.green    = g;
      row.item.blue     = b;
      rows.push_back(row);
   endfunction

   // typed-in result for the row just added
   function automatic void fix(amps_action_type act, logic [15:0] trk, logic [5:0] vol,
                               logic cset, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                               logic pwr, amps_state_type st);
      int unsigned n;
      n = rows.size() - 1;
      rows[n].fixed             = 1'b1;
      rows[n].want.action       = act;
      rows[n].want.track        = trk;
      rows[n].want.volume       = vol;
      rows[n].want.color_set    = cset;
      rows[n].want.red          = r;
      rows[n].want.green        = g;
      rows[n].want.blue         = b;
      rows[n].want.module_power = pwr;
      rows[n].want.state        = st;
   endfunction

   function automatic void build_directed();
      // idle with an empty queue, unused command, edge while not armed
      add(KIND_RUN, 32'd0, 1'b0, '0, '0, '0, '0, '0);
      fix(ACT_NONE, 16'd0, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, ST_IDLE);
      add(KIND_NONE, '1, 1'b1, '1, '1, '1, '1, '1);
      fix(ACT_NONE, 16'd0, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, ST_IDLE);
      add(KIND_EDGE, '1, 1'b1, '1, '1, '1, '1, '1);
      fix(ACT_NONE, 16'd0, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, ST_IDLE);
      // clamping at both ends of the request fields
      add(KIND_REQUEST, 32'd0, 1'b0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      fix(ACT_QUEUED, 16'd255, 6'd30, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0, ST_IDLE);
      add(KIND_REQUEST, '1, 1'b1, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      fix(ACT_QUEUED, 16'd0, 6'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0, ST_IDLE);
      add(KIND_REQUEST, 32'd0, 1'b0, 16'd256, 8'd31, 8'd1, 8'd2, 8'd3);
      fix(ACT_QUEUED, 16'd255, 6'd30, 1'b0, 8'd1, 8'd2, 8'd3, 1'b0, ST_IDLE);
      // first track: power up, boot wait edge, volume with colour, play, end event
      add(KIND_RUN, 32'd100, 1'b0, '0, '0, '0, '0, '0);
      add(KIND_RUN, 32'd100, 1'b0, '0, '0, '0, '0, '0);
      add(KIND_RUN, 32'd1599, 1'b0, '0, '0, '0, '0, '0);
      add(KIND_RUN, 32'd1600, 1'b0, '0, '0, '0, '0, '0);
      add(KIND_RUN, 32'd1600, 1'b0, '0, '0, '0, '0, '0);
      add(KIND_RUN, 32'd1700, 1'b0, '0, '0, '0, '0, '0);
      add(KIND_RUN, 32'd1700, 1'b0, '0, '0, '0, '0, '0);
      add(KIND_EDGE, 32'd0, 1'b0, '0, '0, '0, '0, '0);
      add(KIND_RUN, 32'd1701, 1'b0, '0, '0, '0, '0, '0);
      // track gap, then a track with an all-zero colour
      add(KIND_RUN, 32'd1702, 1'b0, '0, '0, '0, '0, '0);
      add(KIND_RUN, 32'd1902, 1'b0, '0, '0, '0, '0, '0);
      add(KIND_RUN, 32'd1902, 1'b0, '0, '0, '0, '0, '0);
      add(KIND_RUN, 32'd2002, 1'b0, '0, '0, '0, '0, '0);
      add(KIND_RUN, 32'd2002, 1'b0, '0, '0, '0, '0, '0);
      // busy low starts playback; edge and timeout arrive together
      add(KIND_RUN, 32'd2003, 1'b1, '0, '0, '0, '0, '0);
      add(KIND_EDGE, 32'd0, 1'b0, '0, '0, '0, '0, '0);
      add(KIND_RUN, 32'd62003, 1'b0, '0, '0, '0, '0, '0);
      add(KIND_RUN, 32'd62003, 1'b0, '0, '0, '0, '0, '0);
   endfunction

   // ---------------------------------------------------------------
   // random stimulus
   // ---------------------------------------------------------------
   function automatic logic [31:0] time_step();
      int unsigned q;
      q = $urandom_range(0, 99);
      if (q < 20) return 32'd0;
      if (q < 50) return $urandom_range(1, 40);
      if (q < 88) return $urandom_range(0, 70000);
      return $urandom;   // long jumps, wraps included
   endfunction

   function automatic play_item_type random_item();
      play_item_type it;
      int unsigned   p;
      it.kind     = KIND_RUN;
      it.now_ms   = $urandom;
      it.busy_low = 1'($urandom_range(0, 1));
      it.track    = 16'($urandom);
      it.volume   = 8'($urandom);
      it.red      = 8'($urandom);
      it.green    = 8'($urandom);
      it.blue     = 8'($urandom);
      p = $urandom_range(0, 99);
      if (p < 66) begin
         // run step with a monotonic clock and a busy line mostly high
         ms_now      = ms_now + time_step();
         it.now_ms   = ms_now;
         it.busy_low = ($urandom_range(0, 2) == 0);
      end else if (p < 82) begin
         it.kind = KIND_REQUEST;
         if ($urandom_range(0, 1) == 1) it.track = 16'($urandom_range(0, 300));
         if ($urandom_range(0, 4) == 0) {it.red, it.green, it.blue} = '0;
      end else if (p < 97) begin
         it.kind = KIND_EDGE;
      end else begin
         it.kind = KIND_NONE;
      end
      return it;
   endfunction

   // no idling on either side over a middle stretch of the run
   function automatic bit steady();
      return (sent_n >= 150) && (sent_n < 230);
   endfunction

   // ---------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------
   task automatic send_item(play_item_type it, logic fixed, amps_result_type want);
      amps_result_type p;
      // idle cycles drawn one at a time
      while (!steady() && ($urandom_range(0, 99) < 29)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {7'd0, it.blue, it.green, it.red, it.volume, it.track,
                     it.busy_low, it.now_ms};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // transaction accepted at this edge
      p = play_step(it);
      outcome_q.push_back(fixed ? want : p);
      sent_n++;
   endtask

   task automatic write_reg(logic [7:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_reg(idx, val);
   endtask

   // let every outstanding result come back before touching registers
   task automatic drain();
      req_tvalid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register settings: 1 all zero, 2 short waits, 3 all ones, else random
   task automatic load_setting(int unsigned sel);
      logic [31:0] v [8];
      case (sel)
         1: foreach (v[i]) v[i] = '0;
         2: begin
            foreach (v[i]) v[i] = $urandom_range(0, 60);
            v[CSR_START_RETRY]   = $urandom_range(0, 3);
            v[CSR_RESTART_LIMIT] = $urandom_range(0, 2);
            v[CSR_PLAY_TIMEOUT]  = $urandom_range(0, 200);
         end
         3: foreach (v[i]) v[i] = '1;   // upper bits must be dropped
         default: begin
            foreach (v[i]) v[i] = $urandom;
            v[CSR_START_RETRY]   = ($urandom & 32'hFFFF_FF00) | $urandom_range(0, 4);
            v[CSR_RESTART_LIMIT] = ($urandom & 32'hFFFF_FF00) | $urandom_range(0, 3);
         end
      endcase
      foreach (v[i]) write_reg(8'(i), v[i]);
      // unmapped index, must change nothing
      write_reg(8'($urandom_range(8, 255)), $urandom);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------
   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch at result %0d: %s got %0h expected %0h",
               checked_n, what, got, want);
   endtask

   task automatic check_result();
      amps_result_type got;
      amps_result_type want;
      got.action       = amps_action_type'(rsp_tuser);
      got.track        = rsp_tdata[15:0];
      got.volume       = rsp_tdata[21:16];
      got.color_set    = rsp_tdata[22];
      got.red          = rsp_tdata[30:23];
      got.green        = rsp_tdata[38:31];
      got.blue         = rsp_tdata[46:39];
      got.module_power = rsp_tdata[47];
      got.state        = amps_state_type'(rsp_tdata[51:48]);
      if (outcome_q.size() == 0) begin
         report("result with nothing outstanding, action", 32'(got.action), 32'd0);
      end else begin
         want = outcome_q.pop_front();
         checked_n++;
         seen[want.action]++;
         if (got.action != want.action)
            report("action", 32'(got.action), 32'(want.action));
         if (got.track != want.track)
            report("track_out", 32'(got.track), 32'(want.track));
         if (got.volume != want.volume)
            report("volume_out", 32'(got.volume), 32'(want.volume));
         if (got.color_set != want.color_set)
            report("color_set", 32'(got.color_set), 32'(want.color_set));
         if (got.red != want.red)
            report("red_out", 32'(got.red), 32'(want.red));
         if (got.green != want.green)
            report("green_out", 32'(got.green), 32'(want.green));
         if (got.blue != want.blue)
            report("blue_out", 32'(got.blue), 32'(want.blue));
         if (got.module_power != want.module_power)
            report("module_power", 32'(got.module_power), 32'(want.module_power));
         if (got.state != want.state)
            report("state_code", 32'(got.state), 32'(want.state));
      end
   endtask

   // result side: sample at the edge, then pick the next ready level
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_result();
         rsp_tready <= steady() || ($urandom_range(0, 99) >= 29);
      end
   end

   // watchdog
   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, outcome_q.size());
            $display("audio_module_play_sequencer verification failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      int unsigned settings [5];
      settings = '{1, 2, 3, 4, 2};
      foreach (seen[i]) seen[i] = 0;
      clear_sequencer();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table with reset register values
      build_directed();
      foreach (rows[i]) send_item(rows[i].item, rows[i].fixed, rows[i].want);

      // random traffic with reset values, clock close to the wrap
      ms_now = 32'hFFFF_FF00;
      repeat (60) send_item(random_item(), 1'b0, '0);

      // then one random block per register setting
      foreach (settings[s]) begin
         drain();
         load_setting(settings[s]);
         repeat (70) send_item(random_item(), 1'b0, '0);
      end

      drain();
      repeat (10) @(posedge clock);

      $display("sent %0d items under six register settings, checked %0d results",
               sent_n, checked_n);
      $display("seen: %0d queued, %0d dropped, %0d plays, %0d restarts, %0d failed, %0d stops",
               seen[ACT_QUEUED], seen[ACT_DROPPED], seen[ACT_PLAY],
               seen[ACT_RESTART_OFF], seen[ACT_FAILED], seen[ACT_STOP]);
      if (errors == 0 && outcome_q.size() == 0) begin
         $display("audio_module_play_sequencer verification clean");
      end else begin
         $display("audio_module_play_sequencer verification failed");
      end
      $finish;
   end

endmodule
